// ----- rtl/sadf_pkg.sv -----
// shared types and constants of the sector address field framer
package sadf_pkg;

	// fixed part of the header after the gap
	localparam int unsigned SYNC_LEN   = 12;
	localparam int unsigned PRO_LEN    = 3;
	localparam int unsigned ADDR_LEN   = 8;
	localparam int unsigned EPI_LEN    = 3;
	localparam int unsigned TAIL_LEN   = 5;
	localparam int unsigned FIXED_LEN  = SYNC_LEN + PRO_LEN + ADDR_LEN + EPI_LEN + TAIL_LEN;
	localparam int unsigned OFF_W      = 5;

	// offsets of the sections, counted from the end of the gap
	localparam logic [OFF_W-1:0] OFF_PRO  = OFF_W'(SYNC_LEN);
	localparam logic [OFF_W-1:0] OFF_ADDR = OFF_W'(SYNC_LEN + PRO_LEN);
	localparam logic [OFF_W-1:0] OFF_EPI  = OFF_W'(SYNC_LEN + PRO_LEN + ADDR_LEN);
	localparam logic [OFF_W-1:0] OFF_TAIL = OFF_W'(SYNC_LEN + PRO_LEN + ADDR_LEN + EPI_LEN);

	localparam logic [7:0] FILL_BYTE = 8'hff;
	localparam logic [7:0] PRO_0     = 8'hd5;
	localparam logic [7:0] PRO_1     = 8'haa;
	localparam logic [7:0] PRO_2     = 8'h96;
	localparam logic [7:0] EPI_0     = 8'hde;
	localparam logic [7:0] EPI_1     = 8'haa;
	localparam logic [7:0] EPI_2     = 8'heb;
	localparam logic [7:0] ENC_MASK  = 8'haa;
	localparam logic [7:0] VOL_RESET = 8'hfe;

	localparam logic [7:0] SYNC_PAT [SYNC_LEN] = '{
		8'h03, 8'hfc, 8'hff, 8'h3f, 8'hcf, 8'hf3,
		8'hfc, 8'hff, 8'h3f, 8'hcf, 8'hf3, 8'hfc
	};

	// one header byte on its way to the output register
	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} sadf_beat_t;

endpackage

// ----- rtl/sadf_ifs.sv -----
// channel interfaces: request item, header byte item and volume write
interface sadf_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_number;
	logic [7:0] sector_number;
	modport source (output valid, track_number, sector_number, input ready);
	modport sink (input valid, track_number, sector_number, output ready);
endinterface

interface sadf_hdr_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       last_byte;
	modport source (output valid, header_byte, last_byte, input ready);
	modport sink (input valid, header_byte, last_byte, output ready);
endinterface

interface sadf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] volume_number;
	modport source (output valid, volume_number, input ready);
	modport sink (input valid, volume_number, output ready);
endinterface

// ----- rtl/sadf_seq.sv -----
// request register, byte counter and header byte selection
module sadf_seq
	import sadf_pkg::*;
#(
	parameter int unsigned GAP_BYTES = 22
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  logic [7:0]   track_number,
	input  logic [7:0]   sector_number,
	input  logic [7:0]   volume_number,
	output logic         beat_valid,
	input  logic         beat_take,
	output sadf_beat_t   beat
);

	localparam int unsigned HDR_LEN = GAP_BYTES + FIXED_LEN;
	localparam int unsigned CW      = $clog2(HDR_LEN);
	localparam logic [CW-1:0] CNT_LAST = CW'(HDR_LEN - 1);
	localparam logic [CW-1:0] CNT_GAP  = CW'(GAP_BYTES);

	logic          item_v_s1;
	logic [7:0]    trk_s1;
	logic [7:0]    sec_s1;
	logic [7:0]    vol_s1;
	logic [CW-1:0] cnt_q;

	logic          accept;
	logic          advance;
	logic          at_last;
	logic [CW-1:0] rel;
	logic [OFF_W-1:0] off;
	logic [OFF_W-1:0] addr_off;
	logic [7:0]    fld;
	logic [7:0]    hbyte;

	assign at_last   = (cnt_q == CNT_LAST);
	assign advance   = item_v_s1 && beat_take;
	assign req_ready = !item_v_s1 || (advance && at_last);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (accept) begin
				item_v_s1 <= 1'b1;
				cnt_q     <= '0;
			end else if (advance) begin
				if (at_last) begin
					item_v_s1 <= 1'b0;
					cnt_q     <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trk_s1 <= track_number;
			sec_s1 <= sector_number;
			vol_s1 <= volume_number;
		end
	end

	// position after the gap, meaningful only once the gap is done
	assign rel      = cnt_q - CNT_GAP;
	assign off      = rel[OFF_W-1:0];
	assign addr_off = off - OFF_ADDR;

	always_comb begin
		case (addr_off[2:1])
			2'd0:    fld = vol_s1;
			2'd1:    fld = trk_s1;
			2'd2:    fld = sec_s1;
			default: fld = vol_s1 ^ trk_s1 ^ sec_s1;
		endcase
	end

	always_comb begin
		hbyte = FILL_BYTE;
		if (cnt_q >= CNT_GAP) begin
			if (off < OFF_PRO) begin
				hbyte = SYNC_PAT[off[3:0]];
			end else if (off < OFF_ADDR) begin
				if (off == OFF_PRO)
					hbyte = PRO_0;
				else if (off == OFF_PRO + 1'b1)
					hbyte = PRO_1;
				else
					hbyte = PRO_2;
			end else if (off < OFF_EPI) begin
				// odd bits first, then even bits
				hbyte = addr_off[0] ? (fld | ENC_MASK) : ({1'b0, fld[7:1]} | ENC_MASK);
			end else if (off < OFF_TAIL) begin
				if (off == OFF_EPI)
					hbyte = EPI_0;
				else if (off == OFF_EPI + 1'b1)
					hbyte = EPI_1;
				else
					hbyte = EPI_2;
			end
		end
	end

	assign beat_valid       = item_v_s1;
	assign beat.header_byte = hbyte;
	assign beat.last_byte   = at_last;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("byte counter past end of header");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_v_s1 && !beat_take |=> item_v_s1 && $stable(cnt_q))
		else $error("counter moved while output stalled");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_v_s1 && cnt_q == '0)
		else $error("new request did not start at first byte");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && item_v_s1 |-> advance && at_last)
		else $error("request taken while header in progress");
`endif

endmodule

// ----- rtl/sadf_out_stage.sv -----
// output register for header byte items
module sadf_out_stage
	import sadf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        beat_valid,
	output logic        beat_take,
	input  sadf_beat_t  beat,
	sadf_hdr_if.source  hdr
);

	logic       out_v_q;
	sadf_beat_t out_q;

	assign beat_take = !out_v_q || hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (beat_take) begin
			out_v_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_take && beat_valid)
			out_q <= beat;
	end

	assign hdr.valid       = out_v_q;
	assign hdr.header_byte = out_q.header_byte;
	assign hdr.last_byte   = out_q.last_byte;

`ifndef SYNTHESIS
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		beat_valid && beat_take |=> out_v_q && out_q == $past(beat))
		else $error("byte not loaded into output register");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && hdr.ready && !beat_valid |=> !out_v_q)
		else $error("output register kept a delivered byte");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !hdr.ready |-> !beat_take)
		else $error("byte taken over a stalled output");
`endif

endmodule

// ----- rtl/sector_address_field_framer_core.sv -----
// top level of the sector address field framer
//
//  channel  dir  payload                         handshake
//  req      in   track_number, sector_number     valid/ready
//  hdr      out  header_byte, last_byte          valid/ready
//  cfg      in   volume_number                   valid/ready, always ready
//
// each request gives GAP_BYTES + 31 header byte items (53 at the default),
// one per cycle while hdr is not stalled; the byte counter in the sequencer steps through them
// the first byte of a request passes the request register, then the output register
// the next request is taken on the cycle the last byte of the current one
// moves to the output register, so headers follow with no bubble
// a stall on hdr freezes the counter; reset clears all valids, volume to 254
module sector_address_field_framer_core
	import sadf_pkg::*;
#(
	parameter int unsigned GAP_BYTES = 22
) (
	input  logic       clk,
	input  logic       arst_n,
	sadf_req_if.sink   req,
	sadf_hdr_if.source hdr,
	sadf_cfg_if.sink   cfg
);

	logic       vol_wr;
	logic [7:0] vol_q;
	logic       beat_valid;
	logic       beat_take;
	sadf_beat_t beat;

	// volume register; the user must write it only between headers, the block does not enforce it
	assign cfg.ready = 1'b1;
	assign vol_wr    = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= VOL_RESET;
		end else if (vol_wr) begin
			vol_q <= cfg.volume_number;
		end
	end

	// request register, counter and byte selection
	sadf_seq #(
		.GAP_BYTES(GAP_BYTES)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.track_number  (req.track_number),
		.sector_number (req.sector_number),
		.volume_number (vol_q),
		.beat_valid    (beat_valid),
		.beat_take     (beat_take),
		.beat          (beat)
	);

	// output register toward the consumer
	sadf_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat_take  (beat_take),
		.beat       (beat),
		.hdr        (hdr)
	);

endmodule
